// ===== hw/rtl/channel_bandwidth_limiter_assert.svh =====
// assertion macros for the channel bandwidth limiter
`ifndef CHANNEL_BANDWIDTH_LIMITER_ASSERT_SVH
`define CHANNEL_BANDWIDTH_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
`define CBL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`define CBL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define CBL_ASSERT_NEXT(lbl, ante, cons, msg)
`define CBL_ASSERT_SAME(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cbl_pkg.sv =====
// shared types and constants for the channel bandwidth limiter
`default_nettype none
package cbl_pkg;
   localparam int CHANNELS   = 4;
   localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LIMIT_REGS = 4;
   localparam int CHAN_W     = 2;
   localparam int LEN_W      = 16;
   localparam int BW_W       = 31;
   localparam int USED_W     = 32;
   localparam int LIM_W      = 32;
   localparam int LIMREG_W   = 31;
   localparam int WIN_W      = 16;
   localparam int MASK_W     = 4;
   localparam int ELAPSED_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam int PCT_DIVISOR = 100;
   localparam int PCT_W      = $clog2(PCT_DIVISOR);
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);

   // reciprocals of one hundred: exact for any 31-bit operand and for operands below 43690
   localparam int DIV100_SHIFT      = 37;
   localparam logic [BW_W-1:0] DIV100_MAGIC = BW_W'(32'h51EB851F);
   localparam int DIV100_FRAC_W     = 13;
   localparam int DIV100_FRAC_SHIFT = 19;
   localparam logic [DIV100_FRAC_W-1:0] DIV100_FRAC_MAGIC = DIV100_FRAC_W'(5243);

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SEND = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PERCENT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_CH0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_CH1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_CH2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_CH3 = 3'd6;

   typedef struct packed {
      logic              mode;
      logic [CHAN_W-1:0] channel;
      logic [LEN_W-1:0]  data_length;
      logic [BW_W-1:0]   link_bandwidth;
   } cbl_req_type;

   typedef struct packed {
      logic                    granted;
      logic [BW_W-1:0]         used_bytes;
      logic signed [LIM_W-1:0] limit_bytes;
   } cbl_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_DECIDE
   } cbl_state_type;

   function automatic logic chan_present(input logic [CHAN_W-1:0] ch);
      return int'(ch) < CHANNELS;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/channel_bandwidth_limiter.sv =====
// top level of the per-channel fixed-window byte limiter
`default_nettype none
`include "channel_bandwidth_limiter_assert.svh"
// Per-channel fixed-window byte limiter. A request is taken when start is high
// and busy is low; mode tick advances the window clock by one millisecond and
// gives no result, mode send gives exactly one result on rsp_data, strobed by
// rsp_valid for one cycle, which the receiver must take as it comes. A tick
// leaves busy low. A send request keeps busy high in the read state alone when
// the channel has no limit or the length is zero, in read and decide with an
// absolute limit or an out-of-range percent, and in read, divide and decide
// with a valid percent; the divide by one hundred is four pipelined reciprocal
// multiply stages. The byte counters sit in a small ram read at acceptance and
// used the next cycle; the result is strobed in the first cycle with busy low,
// when the next request may already be taken. Window expiry clears all
// counters at once through per-channel valid bits.
module channel_bandwidth_limiter import cbl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire cbl_req_type           req_data,
   output logic                       rsp_valid,
   output cbl_rsp_type                rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   cbl_state_type state_ff, state_in;

   logic [WIN_W-1:0]    window_ff;
   logic [MASK_W-1:0]   enable_ff;
   logic [MASK_W-1:0]   percent_ff;
   logic [LIMREG_W-1:0] limit_reg_ff [LIMIT_REGS];

   cbl_req_type         req_ff, req_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic signed [LIM_W-1:0] limit_ff, limit_in;
   logic                bad_ff, bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cbl_rsp_type         rsp_ff, rsp_in;

   logic                accept;
   logic [CH_AW-1:0]    ram_raddr, ram_waddr;
   logic [USED_W-1:0]   ram_rdata, ram_wdata;
   logic                ram_we;
   logic                div_start, div_done;
   logic [BW_W-1:0]     div_quo;

   logic                have;
   logic                unlimited;
   logic                pct_mode;
   logic                pct_bad;
   logic                expired;
   logic [LIMREG_W-1:0] lim_sel;
   logic [USED_W-1:0]   used_rd;
   logic [USED_W:0]     sum;
   logic                ok;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign ram_raddr = CH_AW'(req_data.channel);
   assign ram_waddr = CH_AW'(req_ff.channel);

   assign have      = chan_present(req_ff.channel);
   assign unlimited = !have || !enable_ff[req_ff.channel] || (req_ff.data_length == '0);
   assign pct_mode  = percent_ff[req_ff.channel];
   assign lim_sel   = limit_reg_ff[req_ff.channel];
   assign pct_bad   = (lim_sel == '0) || (lim_sel > LIMREG_W'(PCT_DIVISOR));
   assign expired   = elapsed_ff > ELAPSED_W'(window_ff);
   // a channel counter not written since the last clear reads as zero
   assign used_rd   = (have && valid_ff[ram_waddr]) ? ram_rdata : '0;
   assign sum       = {1'b0, used_ff} + (USED_W + 1)'(req_ff.data_length);
   assign ok        = !bad_ff && (sum <= (USED_W + 1)'(unsigned'(limit_ff)));

   cbl_ram #(
      .WIDTH(USED_W),
      .DEPTH(CHANNELS)
   ) u_used_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   cbl_div100 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .bandwidth(req_ff.link_bandwidth),
      .percent  (lim_sel[PCT_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.mode == MODE_SEND) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            priority if (unlimited) begin
               state_in = ST_IDLE;
            end else if (pct_mode && !pct_bad) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      elapsed_in   = elapsed_ff;
      valid_in     = valid_ff;
      used_in      = used_ff;
      limit_in     = limit_ff;
      bad_in       = bad_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_wdata    = sum[USED_W-1:0];
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.mode == MODE_TICK && elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + ELAPSED_W'(1);
               end
            end
         end
         ST_READ: begin
            if (unlimited) begin
               rsp_valid_in       = 1'b1;
               rsp_in.granted     = 1'b1;
               rsp_in.used_bytes  = used_rd[BW_W-1:0];
               rsp_in.limit_bytes = '0;
            end else begin
               if (expired) begin
                  valid_in   = '0;
                  elapsed_in = '0;
                  used_in    = '0;
               end else begin
                  used_in = used_rd;
               end
               bad_in    = pct_mode && pct_bad;
               div_start = pct_mode && !pct_bad;
               if (pct_mode && pct_bad) begin
                  limit_in = '1;
               end else begin
                  limit_in = signed'(LIM_W'(lim_sel));
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               limit_in = signed'(LIM_W'(div_quo));
            end
         end
         ST_DECIDE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.granted     = ok;
            rsp_in.limit_bytes = limit_ff;
            if (ok) begin
               ram_we                = 1'b1;
               valid_in[ram_waddr]   = 1'b1;
               rsp_in.used_bytes     = sum[BW_W-1:0];
            end else begin
               rsp_in.used_bytes = used_ff[BW_W-1:0];
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      used_ff  <= used_in;
      limit_ff <= limit_in;
      bad_ff   <= bad_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         enable_ff    <= '0;
         percent_ff   <= '0;
         limit_reg_ff <= '{default: '0};
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW:    window_ff       <= csr_wdata[WIN_W-1:0];
            REG_ENABLE:    enable_ff       <= csr_wdata[MASK_W-1:0];
            REG_PERCENT:   percent_ff      <= csr_wdata[MASK_W-1:0];
            REG_LIMIT_CH0: limit_reg_ff[0] <= csr_wdata[LIMREG_W-1:0];
            REG_LIMIT_CH1: limit_reg_ff[1] <= csr_wdata[LIMREG_W-1:0];
            REG_LIMIT_CH2: limit_reg_ff[2] <= csr_wdata[LIMREG_W-1:0];
            REG_LIMIT_CH3: limit_reg_ff[3] <= csr_wdata[LIMREG_W-1:0];
            default: begin
               window_ff <= window_ff;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CBL_ASSERT_NEXT(a_send_goes_busy, accept && req_data.mode == MODE_SEND, busy, "send request did not start work")
   `CBL_ASSERT_NEXT(a_tick_no_result, accept && req_data.mode == MODE_TICK, !rsp_valid && !busy, "tick produced a result or stalled")
   `CBL_ASSERT_SAME(a_result_when_idle, rsp_valid, !busy, "result strobed while still busy")
   `CBL_ASSERT_SAME(a_bad_limit_refused, rsp_valid && rsp_data.limit_bytes == -32'sd1, !rsp_data.granted, "request granted against an invalid percent")
endmodule
`default_nettype wire

// ===== hw/rtl/cbl_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module cbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic                                        clock,
   input  wire logic                                        we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                            wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cbl_div100.sv =====
// bandwidth times percent divided by one hundred, as a four-stage reciprocal multiply
`default_nettype none
module cbl_div100 import cbl_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [BW_W-1:0]  bandwidth,
   input  wire logic [PCT_W-1:0] percent,
   output logic                  done,
   output logic [BW_W-1:0]       quotient
);
   localparam int MUL_W = 2 * BW_W;
   localparam int Q_W   = MUL_W - DIV100_SHIFT;
   localparam int RP_W  = 2 * PCT_W;
   localparam int FP_W  = RP_W + DIV100_FRAC_W;

   logic [BW_W-1:0]  bw_ff, bw_in;
   logic [PCT_W-1:0] pct_ff, pct_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [PCT_W-1:0] rem_ff, rem_in;
   logic [BW_W-1:0]  hi_ff, hi_in;
   logic [RP_W-1:0]  rp_ff, rp_in;
   logic [BW_W-1:0]  quo_ff, quo_in;
   logic [3:0]       stage_ff, stage_in;
   logic [MUL_W-1:0] recip_prod;
   logic [BW_W-1:0]  q_base;
   logic [BW_W-1:0]  q_pct;
   logic [FP_W-1:0]  frac_prod;

   // bw*p/100 = (bw/100)*p + ((bw%100)*p)/100
   assign recip_prod = MUL_W'(bandwidth) * MUL_W'(DIV100_MAGIC);
   assign q_base     = BW_W'(q_ff) * BW_W'(PCT_DIVISOR);
   assign q_pct      = BW_W'(q_ff) * BW_W'(pct_ff);
   assign frac_prod  = FP_W'(rp_ff) * FP_W'(DIV100_FRAC_MAGIC);

   always_comb begin
      bw_in    = bw_ff;
      pct_in   = pct_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      hi_in    = hi_ff;
      rp_in    = rp_ff;
      quo_in   = quo_ff;
      stage_in = {stage_ff[2:0], start};
      if (start) begin
         bw_in  = bandwidth;
         pct_in = percent;
         q_in   = recip_prod[MUL_W-1:DIV100_SHIFT];
      end
      if (stage_ff[0]) begin
         rem_in = PCT_W'(bw_ff - q_base);
         hi_in  = q_pct;
      end
      if (stage_ff[1]) begin
         rp_in = RP_W'(rem_ff) * RP_W'(pct_ff);
      end
      if (stage_ff[2]) begin
         quo_in = hi_ff + BW_W'(frac_prod[FP_W-1:DIV100_FRAC_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      bw_ff  <= bw_in;
      pct_ff <= pct_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      hi_ff  <= hi_in;
      rp_ff  <= rp_in;
      quo_ff <= quo_in;
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign done     = stage_ff[3];
   assign quotient = quo_ff;
endmodule
`default_nettype wire
